@@ src/bxr_pkg.sv @@
// shared types and constants of the bounded xorshift random unit
package bxr_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned HalfW = 32;
	localparam int unsigned AddrW = 4;

	localparam logic [WordW-1:0] SEED_ZERO_SUB = 64'hA5A5A5A5A5A5A5A5;
	localparam logic [WordW-1:0] SM_GAMMA      = 64'h9E3779B97F4A7C15;
	localparam logic [WordW-1:0] SM_MUL1       = 64'hBF58476D1CE4E5B9;
	localparam logic [WordW-1:0] SM_MUL2       = 64'h94D049BB133111EB;
	localparam logic [WordW-1:0] XS_MUL        = 64'h2545F4914F6CDD1D;
	localparam logic [WordW-1:0] ALL_ONES      = 64'hFFFFFFFFFFFFFFFF;

	// register index taken from the byte address
	localparam logic REG_SEED = 1'b0;

	// one classified request waiting for the back end
	typedef struct packed {
		logic [WordW-1:0] bound;
		logic             zero;
	} req_t;

	// operand request to a shared arithmetic unit
	typedef struct packed {
		logic             start;
		logic [WordW-1:0] a;
		logic [WordW-1:0] b;
	} op_req_t;

	// result of a shared arithmetic unit
	typedef struct packed {
		logic             done;
		logic [WordW-1:0] res;
	} op_rsp_t;

endpackage

@@ src/bxr_front.sv @@
// front end: takes bound beats and classifies zero bounds
module bxr_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [bxr_pkg::WordW-1:0]  bound,
	output logic                       req_valid,
	input  logic                       req_ready,
	output bxr_pkg::req_t              req
);

	logic          full_q;
	bxr_pkg::req_t req_s1;

	assign in_ready  = !full_q || req_ready;
	assign req_valid = full_q;
	assign req       = req_s1;

	// stage register holding one classified beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			full_q <= 1'b1;
		end else if (req_ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.bound <= bound;
			req_s1.zero  <= (bound == '0);
		end
	end

endmodule

@@ src/bxr_queue.sv @@
// two-entry queue between front and back end
module bxr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  bxr_pkg::req_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output bxr_pkg::req_t pop_data
);

	bxr_pkg::req_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ src/bxr_div.sv @@
// restoring divider, one quotient bit a cycle, remainder only
module bxr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bxr_pkg::op_req_t  req,
	output bxr_pkg::op_rsp_t  rsp
);

	localparam int unsigned CntW = $clog2(bxr_pkg::WordW + 1);

	logic [bxr_pkg::WordW-1:0] dvd_q;
	logic [bxr_pkg::WordW-1:0] dvs_q;
	logic [bxr_pkg::WordW:0]   rem_q;
	logic [CntW-1:0]           cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [bxr_pkg::WordW:0]   trial;
	logic [bxr_pkg::WordW:0]   diff;

	// shift in next dividend bit and try the subtract
	assign trial = {rem_q[bxr_pkg::WordW-1:0], dvd_q[bxr_pkg::WordW-1]};
	assign diff  = trial - {1'b0, dvs_q};

	assign rsp.done = done_q;
	assign rsp.res  = rem_q[bxr_pkg::WordW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(bxr_pkg::WordW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.a;
			dvs_q <= req.b;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[bxr_pkg::WordW-2:0], 1'b0};
			rem_q <= diff[bxr_pkg::WordW] ? trial : diff;
		end
	end

endmodule

@@ src/bxr_mul.sv @@
// 64 by 64 multiplier, low word, from three 32 by 32 products
module bxr_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  bxr_pkg::op_req_t  req,
	output bxr_pkg::op_rsp_t  rsp
);

	localparam int unsigned H = bxr_pkg::HalfW;

	logic [bxr_pkg::WordW-1:0] a_q;
	logic [bxr_pkg::WordW-1:0] b_q;
	logic [bxr_pkg::WordW-1:0] acc_q;
	logic [1:0]                step_q;
	logic                      busy_q;
	logic                      done_q;
	logic [H-1:0]              opa;
	logic [H-1:0]              opb;
	logic [bxr_pkg::WordW-1:0] prod;

	// pick the partial product of this step
	always_comb begin
		unique case (step_q)
			2'd0: begin
				opa = a_q[H-1:0];
				opb = b_q[H-1:0];
			end
			2'd1: begin
				opa = a_q[bxr_pkg::WordW-1:H];
				opb = b_q[H-1:0];
			end
			default: begin
				opa = a_q[H-1:0];
				opb = b_q[bxr_pkg::WordW-1:H];
			end
		endcase
	end

	assign prod     = {{H{1'b0}}, opa} * {{H{1'b0}}, opb};
	assign rsp.done = done_q;
	assign rsp.res  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// cross terms only reach the upper half of the low word
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			if (step_q == 2'd0) begin
				acc_q <= prod;
			end else begin
				acc_q <= {acc_q[bxr_pkg::WordW-1:H] + prod[H-1:0], acc_q[H-1:0]};
			end
		end
	end

endmodule

@@ src/bxr_back.sv @@
// back end: seeding, generator, rejection loop and reduction
module bxr_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [bxr_pkg::WordW-1:0]  seed,
	input  logic                       seed_wr,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  bxr_pkg::req_t              req,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [bxr_pkg::WordW-1:0]  value,
	output logic                       bad_bound
);

	typedef enum logic [3:0] {
		S_SEED0, S_SEED1, S_SEED2, S_IDLE, S_REM, S_ADV, S_XMUL, S_MOD, S_OUT
	} state_t;

	state_t                    state_q;
	logic [bxr_pkg::WordW-1:0] gen_q;
	logic [bxr_pkg::WordW-1:0] n_q;
	logic [bxr_pkg::WordW-1:0] rem_q;
	logic [bxr_pkg::WordW-1:0] value_q;
	logic                      bad_q;
	logic                      valid_q;
	logic                      reseed_q;
	bxr_pkg::op_req_t          mul_req_q;
	bxr_pkg::op_req_t          div_req_q;
	bxr_pkg::op_rsp_t          mul_rsp;
	bxr_pkg::op_rsp_t          div_rsp;
	logic [bxr_pkg::WordW-1:0] z0;
	logic [bxr_pkg::WordW-1:0] x1;
	logic [bxr_pkg::WordW-1:0] x2;
	logic [bxr_pkg::WordW-1:0] x3;
	logic [bxr_pkg::WordW-1:0] v;
	logic [bxr_pkg::WordW-1:0] rem1;

	bxr_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req_q), .rsp(mul_rsp));
	bxr_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req_q), .rsp(div_rsp));

	// seed mixing and xorshift steps
	assign z0   = seed + bxr_pkg::SM_GAMMA;
	assign v    = mul_rsp.res ^ (mul_rsp.res >> 31);
	assign x1   = gen_q ^ (gen_q >> 12);
	assign x2   = x1 ^ (x1 << 25);
	assign x3   = x2 ^ (x2 >> 27);
	assign rem1 = div_rsp.res + bxr_pkg::WordW'(1);

	assign req_ready = (state_q == S_IDLE) && !seed_wr && !reseed_q;
	assign out_valid = valid_q;
	assign value     = value_q;
	assign bad_bound = bad_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_SEED0;
			valid_q         <= 1'b0;
			reseed_q        <= 1'b0;
			mul_req_q.start <= 1'b0;
			div_req_q.start <= 1'b0;
		end else begin
			mul_req_q.start <= 1'b0;
			div_req_q.start <= 1'b0;
			// a seed write while busy reseeds once back in idle
			if (seed_wr && state_q != S_IDLE) begin
				reseed_q <= 1'b1;
			end else if (state_q == S_IDLE) begin
				reseed_q <= 1'b0;
			end
			unique case (state_q)
				S_SEED0: begin
					mul_req_q <= '{start: 1'b1, a: z0 ^ (z0 >> 30), b: bxr_pkg::SM_MUL1};
					state_q   <= S_SEED1;
				end
				S_SEED1: begin
					if (mul_rsp.done) begin
						mul_req_q <= '{start: 1'b1, a: mul_rsp.res ^ (mul_rsp.res >> 27),
							b: bxr_pkg::SM_MUL2};
						state_q   <= S_SEED2;
					end
				end
				S_SEED2: begin
					if (mul_rsp.done) begin
						gen_q   <= (v == '0) ? bxr_pkg::SEED_ZERO_SUB : v;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					priority if (seed_wr || reseed_q) begin
						state_q <= S_SEED0;
					end else if (req_valid) begin
						n_q <= req.bound;
						if (req.zero) begin
							value_q <= '0;
							bad_q   <= 1'b1;
							valid_q <= 1'b1;
							state_q <= S_OUT;
						end else begin
							div_req_q <= '{start: 1'b1, a: bxr_pkg::ALL_ONES, b: req.bound};
							state_q   <= S_REM;
						end
					end
				end
				S_REM: begin
					// (2^64 - 1) mod n plus one, wrapped at n
					if (div_rsp.done) begin
						rem_q   <= (rem1 == n_q) ? '0 : rem1;
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					gen_q     <= x3;
					mul_req_q <= '{start: 1'b1, a: x3, b: bxr_pkg::XS_MUL};
					state_q   <= S_XMUL;
				end
				S_XMUL: begin
					// accept below 2^64 - rem, else draw again
					if (mul_rsp.done) begin
						if (rem_q == '0 || mul_rsp.res < (~rem_q + bxr_pkg::WordW'(1))) begin
							div_req_q <= '{start: 1'b1, a: mul_rsp.res, b: n_q};
							state_q   <= S_MOD;
						end else begin
							state_q <= S_ADV;
						end
					end
				end
				S_MOD: begin
					if (div_rsp.done) begin
						value_q <= div_rsp.res;
						bad_q   <= 1'b0;
						valid_q <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						valid_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ src/bounded_xorshift_random_unit.sv @@
// top level: seed register port, front end, queue and back end
// zero bounds skip the divider; other bounds take two divides on the serial divider and one
// draw on the multiplier, plus one more draw per rejection; the back end takes one beat at a time
// reset: asynchronous, clears control; the generator is then seeded from seed 0,
// and a seed write reseeds it while bound beats wait
module bounded_xorshift_random_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bxr_pkg::AddrW-1:0]   paddr,
	input  logic [bxr_pkg::WordW-1:0]   pwdata,
	output logic [bxr_pkg::WordW-1:0]   prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bxr_pkg::WordW-1:0]   bound,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bxr_pkg::WordW-1:0]   value,
	output logic                        bad_bound
);

	logic [bxr_pkg::WordW-1:0] seed_q;
	logic                      seed_wr;
	logic                      fr_valid;
	logic                      fr_ready;
	bxr_pkg::req_t             fr_req;
	logic                      bk_valid;
	logic                      bk_ready;
	bxr_pkg::req_t             bk_req;

	// register port
	assign pready  = 1'b1;
	assign seed_wr = psel && penable && pwrite && (paddr[3] == bxr_pkg::REG_SEED);
	assign prdata  = (paddr[3] == bxr_pkg::REG_SEED) ? seed_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (seed_wr) begin
			seed_q <= pwdata;
		end
	end

	bxr_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.bound(bound), .req_valid(fr_valid), .req_ready(fr_ready), .req(fr_req)
	);

	bxr_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push_valid(fr_valid), .push_ready(fr_ready),
		.push_data(fr_req), .pop_valid(bk_valid), .pop_ready(bk_ready), .pop_data(bk_req)
	);

	bxr_back u_back (
		.clk(clk), .arst_n(arst_n), .seed(seed_q), .seed_wr(seed_wr),
		.req_valid(bk_valid), .req_ready(bk_ready), .req(bk_req),
		.out_valid(out_valid), .out_ready(out_ready), .value(value), .bad_bound(bad_bound)
	);

endmodule

@@ src/bxr_checker.sv @@
// port checker for the bounded xorshift random unit, with its bind
module bxr_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bxr_pkg::AddrW-1:0]   paddr,
	input  logic [bxr_pkg::WordW-1:0]   pwdata,
	input  logic [bxr_pkg::WordW-1:0]   prdata,
	input  logic                        pready,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [bxr_pkg::WordW-1:0]   value,
	input  logic                        bad_bound
);

	// register port never stalls
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	// zero bound beat carries zero value
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_bound |-> value == '0)
		else $error("bad bound with nonzero value");

	// seed write reads back on the next cycle
	a_seed_rd: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && !paddr[3] ##1 !paddr[3]
		|-> prdata == $past(pwdata))
		else $error("seed readback mismatch");

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(bad_bound))
		else $error("result beat changed while stalled");

endmodule

bind bounded_xorshift_random_unit bxr_checker u_bxr_checker (
	.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
	.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
	.out_valid(out_valid), .out_ready(out_ready), .value(value), .bad_bound(bad_bound)
);

@@ tb/tb_bounded_xorshift_random_unit.sv @@
// testbench of the bounded xorshift random unit: seed writes, bound beats, scoreboard checks
module tb_bounded_xorshift_random_unit;

	// register index of the seed register
	localparam int unsigned SeedIdx = 0;
	localparam int unsigned NumDirected = 14;

	typedef struct packed {
		logic [bxr_pkg::WordW-1:0] value;
		logic                      bad_bound;
	} draw_t;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [bxr_pkg::AddrW-1:0]   paddr;
	logic [bxr_pkg::WordW-1:0]   pwdata;
	logic [bxr_pkg::WordW-1:0]   prdata;
	logic                        pready;
	logic                        in_valid;
	logic                        in_ready;
	logic [bxr_pkg::WordW-1:0]   bound;
	logic                        out_valid;
	logic                        out_ready;
	logic [bxr_pkg::WordW-1:0]   value;
	logic                        bad_bound;

	// generator copy kept in step with the block
	logic [bxr_pkg::WordW-1:0] gen_copy;
	draw_t                     pending_draws[$];
	int unsigned               mismatch_cnt;
	int unsigned               send_idle_pct;
	int unsigned               recv_idle_pct;

	// directed bounds; dir_known marks rows with a result known at a glance
	logic [bxr_pkg::WordW-1:0] dir_bound [NumDirected];
	logic                      dir_known [NumDirected];
	draw_t                     dir_draw  [NumDirected];

	bounded_xorshift_random_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.bound     (bound),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.bad_bound (bad_bound)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// splitmix64 of a seed, with the zero substitute
	function automatic logic [bxr_pkg::WordW-1:0] seeded_state(
		input logic [bxr_pkg::WordW-1:0] s);
		logic [bxr_pkg::WordW-1:0] z;
		z = s + bxr_pkg::SM_GAMMA;
		z = (z ^ (z >> 30)) * bxr_pkg::SM_MUL1;
		z = (z ^ (z >> 27)) * bxr_pkg::SM_MUL2;
		z = z ^ (z >> 31);
		return (z == '0) ? bxr_pkg::SEED_ZERO_SUB : z;
	endfunction

	// unbiased draw below n, advancing the generator copy
	function automatic draw_t next_draw(input logic [bxr_pkg::WordW-1:0] n);
		draw_t                     d;
		logic [bxr_pkg::WordW-1:0] rem;
		logic [bxr_pkg::WordW-1:0] limit;
		logic [bxr_pkg::WordW-1:0] x;
		logic [bxr_pkg::WordW-1:0] out;
		d.value     = '0;
		d.bad_bound = 1'b1;
		if (n == '0)
			return d;
		rem   = ((bxr_pkg::ALL_ONES % n) + 64'd1) % n;
		limit = 64'd0 - rem;
		forever begin
			x = gen_copy;
			x = x ^ (x >> 12);
			x = x ^ (x << 25);
			x = x ^ (x >> 27);
			gen_copy = x;
			out = x * bxr_pkg::XS_MUL;
			if (rem == '0 || out < limit)
				break;
		end
		d.value     = out % n;
		d.bad_bound = 1'b0;
		return d;
	endfunction

	// random 64-bit bound, mostly small magnitudes
	function automatic logic [bxr_pkg::WordW-1:0] rand_bound();
		logic [bxr_pkg::WordW-1:0] b;
		int unsigned               sel;
		int unsigned               sh;
		b   = {$urandom, $urandom};
		sel = $urandom_range(0, 9);
		sh  = $urandom_range(0, 63);
		unique case (sel)
			0: b = '0;
			1: b = 64'd1 << sh;
			2: b = b >> sh;
			3: b = bxr_pkg::ALL_ONES - (b >> sh);
			4: b = (64'd1 << 63) + (b >> sh);
			default: b = b >> $urandom_range(32, 63);
		endcase
		return b;
	endfunction

	// seed register write, setup then access phase, with the predictor reseeded
	task automatic write_seed(input logic [bxr_pkg::WordW-1:0] s);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= bxr_pkg::AddrW'(SeedIdx * 8);
		pwdata  <= s;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		gen_copy = seeded_state(s);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// write to an unused index is ignored
	task automatic write_unused(input logic [bxr_pkg::WordW-1:0] s);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= bxr_pkg::AddrW'(8);
		pwdata  <= s;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// one bound beat; called at a falling edge, returns at a falling edge with valid still high
	task automatic send_bound(input logic [bxr_pkg::WordW-1:0] n, input logic known,
		input draw_t want);
		draw_t d;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		bound    <= n;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		d = next_draw(n);
		if (known)
			d = want;
		pending_draws = {pending_draws, d};
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_draws.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		draw_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_draws.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected beat: value %h bad_bound %b", value, bad_bound);
			end else begin
				want = pending_draws.pop_front();
				if (value !== want.value || bad_bound !== want.bad_bound) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("beat mismatch: want %h/%b got %h/%b",
							want.value, want.bad_bound, value, bad_bound);
				end
			end
		end
	end

	// stimulus
	initial begin
		int unsigned ph;
		mismatch_cnt  = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		bound     = '0;
		out_ready = 1'b0;
		gen_copy  = seeded_state('0);
		// table: zero bound, one, small values, powers of two, extremes and bit patterns
		dir_bound[0]  = '0;              dir_known[0]  = 1'b1; dir_draw[0]  = '{'0, 1'b1};
		dir_bound[1]  = 64'd1;           dir_known[1]  = 1'b1; dir_draw[1]  = '{'0, 1'b0};
		dir_bound[2]  = 64'd2;           dir_known[2]  = 1'b0; dir_draw[2]  = '0;
		dir_bound[3]  = 64'd3;           dir_known[3]  = 1'b0; dir_draw[3]  = '0;
		dir_bound[4]  = 64'd52;          dir_known[4]  = 1'b0; dir_draw[4]  = '0;
		dir_bound[5]  = 64'd1 << 63;     dir_known[5]  = 1'b0; dir_draw[5]  = '0;
		dir_bound[6]  = bxr_pkg::ALL_ONES; dir_known[6] = 1'b0; dir_draw[6] = '0;
		dir_bound[7]  = (64'd1 << 63) + 1; dir_known[7] = 1'b0; dir_draw[7] = '0;
		dir_bound[8]  = 64'h5555555555555555; dir_known[8] = 1'b0; dir_draw[8] = '0;
		dir_bound[9]  = 64'hAAAAAAAAAAAAAAAA; dir_known[9] = 1'b0; dir_draw[9] = '0;
		dir_bound[10] = 64'd1 << 32;     dir_known[10] = 1'b0; dir_draw[10] = '0;
		dir_bound[11] = '0;              dir_known[11] = 1'b1; dir_draw[11] = '{'0, 1'b1};
		dir_bound[12] = 64'd7;           dir_known[12] = 1'b0; dir_draw[12] = '0;
		dir_bound[13] = 64'd1;           dir_known[13] = 1'b1; dir_draw[13] = '{'0, 1'b0};
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		repeat (20) @(negedge clk);
		// directed part on reset seed, then on the all-ones seed
		for (int i = 0; i < NumDirected; i++)
			send_bound(dir_bound[i], dir_known[i], dir_draw[i]);
		wait_drain();
		write_seed(bxr_pkg::ALL_ONES);
		repeat (20) @(negedge clk);
		write_unused(64'h0123456789ABCDEF);
		for (int i = 0; i < NumDirected; i++)
			send_bound(dir_bound[i], dir_known[i], dir_draw[i]);
		wait_drain();
		// random part in three idling phases, reseeded each time
		for (ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 53 : 0;
			recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 13 : 0;
			write_seed({$urandom, $urandom});
			repeat (20) @(negedge clk);
			for (int k = 0; k < 575; k++) begin
				send_bound(rand_bound(), 1'b0, '0);
				if (k == 300)
					wait_drain();
			end
			wait_drain();
		end
		write_seed('0);
		repeat (20) @(negedge clk);
		send_bound(64'd52, 1'b0, '0);
		wait_drain();
		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
